// File: rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// shared types and constants for the sorted insertion list
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VAL_W        = 31;
    localparam int ENT_W        = 5;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    localparam logic [2:0] K_INSERTED = 3'd0;
    localparam logic [2:0] K_FULL     = 3'd1;
    localparam logic [2:0] K_DELETED  = 3'd2;
    localparam logic [2:0] K_MISSING  = 3'd3;
    localparam logic [2:0] K_ENTRY    = 3'd4;
    localparam logic [2:0] K_EMPTY    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic load;      // capture request
        logic do_ins;    // shift-insert into cells
        logic do_del;    // shift-delete from cells
        logic dump_clr;  // reset dump pointer
        logic dump_step; // advance dump pointer
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic dump_end;  // pointer at final entry
    } t_status;

endpackage

// File: rtl/sorted_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top
// bounded ascending list with insert, delete and dump
// ----------------------------------------------------------------------------
// Insert and delete first capture the beat; then, once the output register is
// free, every cell compares against the value in parallel and the row shifts.
// A dump clears the read pointer on capture and then returns the stored entries
// in order as the read pointer steps over the cells. The next beat is taken once
// the previous item's final result has been loaded into the output register.
module sorted_list_insert_delete_top #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    input  logic [sli_pkg::VAL_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_kind,
    output logic [sli_pkg::VAL_W-1:0] o_value_res,
    output logic [sli_pkg::ENT_W-1:0] o_entries,
    output logic                      o_last
);
    sli_pkg::t_cmd    w_cmd;
    sli_pkg::t_status w_status;
    logic [sli_pkg::VAL_W-1:0] w_req, w_dump;
    logic [sli_pkg::ENT_W-1:0] w_ent;

    sli_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_value(i_value),
        .o_status(w_status), .o_req_value(w_req), .o_dump_value(w_dump),
        .o_entries(w_ent)
    );

    sli_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_value_res(o_value_res), .o_entries(o_entries),
        .o_last(o_last), .o_cmd(w_cmd), .i_status(w_status),
        .i_req_value(w_req), .i_dump_value(w_dump), .i_entries(w_ent)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_value_res))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("beat accepted while busy");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == sli_pkg::K_EMPTY |-> o_last && o_entries == '0)
        else $error("empty dump result malformed");
endmodule

// File: rtl/sli_datapath.sv
// ----------------------------------------------------------------------------
// sli_datapath
// row of cells with parallel compare, shift insert and delete, dump pointer
// ----------------------------------------------------------------------------
module sli_datapath #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sli_pkg::t_cmd            i_cmd,
    input  logic [sli_pkg::VAL_W-1:0] i_value,
    output sli_pkg::t_status         o_status,
    output logic [sli_pkg::VAL_W-1:0] o_req_value,
    output logic [sli_pkg::VAL_W-1:0] o_dump_value,
    output logic [sli_pkg::ENT_W-1:0] o_entries
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);

    logic [sli_pkg::VAL_W-1:0] r_cell [CAPACITY];
    logic [sli_pkg::VAL_W-1:0] r_req;
    logic [CW-1:0]             r_fill;
    logic [PW-1:0]             r_ptr;

    logic [CAPACITY-1:0] w_occ, w_gt, w_eq, w_eq_first, w_eq_before, w_ins_at;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_occ[i] = CW'(i) < r_fill;
            w_gt[i]  = w_occ[i] && (r_cell[i] > r_req);
            w_eq[i]  = w_occ[i] && (r_cell[i] == r_req);
        end
        // thermometer of matches at or below each position
        w_eq_before[0] = w_eq[0];
        for (int i = 1; i < CAPACITY; i++)
            w_eq_before[i] = w_eq_before[i-1] | w_eq[i];
        w_eq_first[0] = w_eq[0];
        for (int i = 1; i < CAPACITY; i++)
            w_eq_first[i] = w_eq[i] & ~w_eq_before[i-1];
        // insert lands at first cell greater than value, or at fill
        for (int i = 0; i < CAPACITY; i++)
            w_ins_at[i] = w_gt[i] || (CW'(i) == r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_value;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.do_ins && w_ins_at[i]) begin
                if (i == 0 || !w_ins_at[(i == 0) ? 0 : i-1])
                    r_cell[i] <= r_req;
                else
                    r_cell[i] <= r_cell[(i == 0) ? 0 : i-1];
            end else if (i_cmd.do_del && w_eq_before[i] && i < CAPACITY-1) begin
                r_cell[i] <= r_cell[(i < CAPACITY-1) ? i+1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ptr  <= '0;
        end else begin
            if (i_cmd.do_ins && r_fill != CW'(CAPACITY)) r_fill <= r_fill + 1'b1;
            else if (i_cmd.do_del && (|w_eq)) r_fill <= r_fill - 1'b1;
            if (i_cmd.dump_clr) r_ptr <= '0;
            else if (i_cmd.dump_step) r_ptr <= r_ptr + 1'b1;
        end
    end

    assign o_status.full     = r_fill == CW'(CAPACITY);
    assign o_status.empty    = r_fill == '0;
    assign o_status.found    = |w_eq_first;
    assign o_status.dump_end = (CW'(r_ptr) + 1'b1) == r_fill;
    assign o_req_value       = r_req;
    assign o_dump_value      = r_cell[r_ptr];
    assign o_entries         = sli_pkg::ENT_W'(r_fill);
endmodule

// File: rtl/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl
// sequencer for insert, delete and dump, drives the output register
// ----------------------------------------------------------------------------
module sli_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_kind,
    output logic [sli_pkg::VAL_W-1:0] o_value_res,
    output logic [sli_pkg::ENT_W-1:0] o_entries,
    output logic                      o_last,
    output sli_pkg::t_cmd             o_cmd,
    input  sli_pkg::t_status          i_status,
    input  logic [sli_pkg::VAL_W-1:0] i_req_value,
    input  logic [sli_pkg::VAL_W-1:0] i_dump_value,
    input  logic [sli_pkg::ENT_W-1:0] i_entries
);
    sli_pkg::t_state r_state, n_state;
    logic [1:0] r_act;
    logic       r_ovalid, n_ovalid;
    logic [2:0] r_kind, n_kind;
    logic [sli_pkg::VAL_W-1:0] r_val, n_val;
    logic [sli_pkg::ENT_W-1:0] r_ent, n_ent;
    logic       r_last, n_last;
    logic       w_free, w_acc;

    assign w_free  = !r_ovalid || i_ready;
    assign o_ready = (r_state == sli_pkg::ST_IDLE);
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sli_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        if (w_acc) r_act <= i_action;
        r_kind <= n_kind;
        r_val  <= n_val;
        r_ent  <= n_ent;
        r_last <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_ready;
        n_kind   = r_kind;
        n_val    = r_val;
        n_ent    = r_ent;
        n_last   = r_last;
        o_cmd    = '0;
        case (r_state)
            sli_pkg::ST_IDLE: begin
                if (w_acc) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.dump_clr = 1'b1;
                    n_state = sli_pkg::ST_EXEC;
                end
            end
            sli_pkg::ST_EXEC: begin
                if (w_free) begin
                    n_state = sli_pkg::ST_IDLE;
                    n_val   = i_req_value;
                    n_last  = 1'b1;
                    case (r_act)
                        sli_pkg::ACT_INSERT: begin
                            n_ovalid = 1'b1;
                            o_cmd.do_ins = !i_status.full;
                            n_kind = i_status.full ? sli_pkg::K_FULL : sli_pkg::K_INSERTED;
                            n_ent  = i_status.full ? i_entries : i_entries + 1'b1;
                        end
                        sli_pkg::ACT_DELETE: begin
                            n_ovalid = 1'b1;
                            o_cmd.do_del = i_status.found;
                            n_kind = i_status.found ? sli_pkg::K_DELETED : sli_pkg::K_MISSING;
                            n_ent  = i_status.found ? i_entries - 1'b1 : i_entries;
                        end
                        sli_pkg::ACT_DUMP: begin
                            n_ovalid = 1'b1;
                            n_ent    = i_entries;
                            if (i_status.empty) begin
                                n_kind = sli_pkg::K_EMPTY;
                                n_val  = '0;
                            end else begin
                                n_kind = sli_pkg::K_ENTRY;
                                n_val  = i_dump_value;
                                n_last = i_status.dump_end;
                                o_cmd.dump_step = 1'b1;
                                if (!i_status.dump_end) n_state = sli_pkg::ST_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sli_pkg::ST_DUMP: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_kind   = sli_pkg::K_ENTRY;
                    n_val    = i_dump_value;
                    n_ent    = i_entries;
                    n_last   = i_status.dump_end;
                    o_cmd.dump_step = 1'b1;
                    if (i_status.dump_end) n_state = sli_pkg::ST_IDLE;
                end
            end
            default: n_state = sli_pkg::ST_IDLE;
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_kind      = r_kind;
    assign o_value_res = r_val;
    assign o_entries   = r_ent;
    assign o_last      = r_last;
endmodule

// File: tb/sv/sorted_list_insert_delete_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top_tb
// checks insert, delete and dump of the sorted list against a local copy
// ----------------------------------------------------------------------------
// Each beat sent is applied to a shadow list kept in the testbench, which
// queues the results it should cause. A monitor compares every result beat
// with the oldest queued one. Both sides idle in random bursts, except in the final random run.
module sorted_list_insert_delete_top_tb;

    localparam int CAP = sli_pkg::CAPACITY_DEF;
    localparam int VW  = sli_pkg::VAL_W;
    localparam int EW  = sli_pkg::ENT_W;

    // action code with no operation behind it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]    kind;
        logic [VW-1:0] value;
        logic [EW-1:0] entries;
        logic          last;
    } t_res;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [1:0]    i_action;
    logic [VW-1:0] i_value;
    logic          o_valid;
    logic          i_ready;
    logic [2:0]    o_kind;
    logic [VW-1:0] o_value_res;
    logic [EW-1:0] o_entries;
    logic          o_last;

    logic [VW-1:0] shadow_list[$];
    t_res          pending_res[$];
    int            err_cnt;
    bit            rx_idle_en;
    bit            tx_idle_en;
    int            rx_hold;

    sorted_list_insert_delete_top #(.CAPACITY(CAP)) u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("sorted_list_insert_delete_top regression: fail");
        $finish;
    end

    task automatic report(input string what, input t_res got, input t_res exp);
        $display("mismatch %s: got k%0d v%0h n%0d l%0d exp k%0d v%0h n%0d l%0d", what,
                 got.kind, got.value, got.entries, got.last,
                 exp.kind, exp.value, exp.entries, exp.last);
        err_cnt++;
    endtask

    function automatic t_res mk(logic [2:0] k, logic [VW-1:0] v, logic l);
        t_res r;
        r.kind = k;
        r.value = v;
        r.entries = EW'(shadow_list.size());
        r.last = l;
        return r;
    endfunction

    // apply one beat to the shadow list and queue its results
    function automatic void list_apply(logic [1:0] act, logic [VW-1:0] v);
        int pos;
        pos = -1;
        case (act)
            sli_pkg::ACT_INSERT: begin
                if (shadow_list.size() >= CAP) begin
                    pending_res.push_back(mk(sli_pkg::K_FULL, v, 1'b1));
                end else begin
                    pos = shadow_list.size();
                    foreach (shadow_list[i])
                        if (pos == shadow_list.size() && shadow_list[i] > v) pos = i;
                    shadow_list.insert(pos, v);
                    pending_res.push_back(mk(sli_pkg::K_INSERTED, v, 1'b1));
                end
            end
            sli_pkg::ACT_DELETE: begin
                foreach (shadow_list[i])
                    if (pos < 0 && shadow_list[i] == v) pos = i;
                if (pos < 0) begin
                    pending_res.push_back(mk(sli_pkg::K_MISSING, v, 1'b1));
                end else begin
                    shadow_list.delete(pos);
                    pending_res.push_back(mk(sli_pkg::K_DELETED, v, 1'b1));
                end
            end
            sli_pkg::ACT_DUMP: begin
                if (shadow_list.size() == 0)
                    pending_res.push_back(mk(sli_pkg::K_EMPTY, '0, 1'b1));
                foreach (shadow_list[i])
                    pending_res.push_back(mk(sli_pkg::K_ENTRY, shadow_list[i],
                                             i == shadow_list.size() - 1));
            end
            default: ;
        endcase
    endfunction

    // valid stays up between back to back beats and drops only for idling or draining
    task automatic send_beat(input logic [1:0] act, input logic [VW-1:0] v);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= v;
        do @(posedge i_clk); while (!o_ready);
        list_apply(act, v);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver stalls
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                rx_hold = $urandom_range(1, 12);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        t_res got, exp;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = '{o_kind, o_value_res, o_entries, o_last};
                if (pending_res.size() == 0) begin
                    report("unexpected", got, got);
                end else begin
                    exp = pending_res.pop_front();
                    if (got.kind !== exp.kind) report("kind", got, exp);
                    else if (got.value !== exp.value) report("value", got, exp);
                    else if (got.entries !== exp.entries) report("entries", got, exp);
                    else if (got.last !== exp.last) report("last", got, exp);
                end
            end
        end
    end

    task automatic test_empty_and_extremes();
        send_beat(sli_pkg::ACT_DUMP, '0);
        send_beat(sli_pkg::ACT_DELETE, 31'd5);
        send_beat(sli_pkg::ACT_INSERT, '1);
        send_beat(sli_pkg::ACT_INSERT, '0);
        send_beat(sli_pkg::ACT_INSERT, 31'd7);
        send_beat(sli_pkg::ACT_INSERT, 31'd7);
        send_beat(sli_pkg::ACT_DUMP, 31'h2aaa_aaaa);
        send_beat(ACT_UNUSED, 31'd7);
        send_beat(sli_pkg::ACT_DELETE, 31'd7);
        send_beat(sli_pkg::ACT_DELETE, '1);
        send_beat(sli_pkg::ACT_DELETE, '0);
        send_beat(sli_pkg::ACT_DUMP, '0);
    endtask

    task automatic test_full_list();
        while (shadow_list.size() < CAP)
            send_beat(sli_pkg::ACT_INSERT, VW'($urandom_range(0, 9)));
        send_beat(sli_pkg::ACT_INSERT, 31'h5555_5555);
        send_beat(sli_pkg::ACT_DUMP, '0);
        send_beat(sli_pkg::ACT_DELETE, shadow_list[0]);
    endtask

    // receiver held off while beats keep coming, so the input stalls
    task automatic test_backpressure();
        rx_hold = 60;
        repeat (6) send_beat(sli_pkg::ACT_DUMP, '0);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        logic [1:0]    act;
        logic [VW-1:0] v;
        int            sel;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) act = sli_pkg::ACT_INSERT;
            else if (sel < 80) act = sli_pkg::ACT_DELETE;
            else if (sel < 96) act = sli_pkg::ACT_DUMP;
            else act = ACT_UNUSED;
            // small values for duplicates, occasional full width
            v = ($urandom_range(0, 3) == 0) ? VW'($urandom) : VW'($urandom_range(0, 15));
            if (act == sli_pkg::ACT_DELETE && shadow_list.size() != 0 && $urandom_range(0, 1))
                v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
            send_beat(act, v);
        end
    endtask

    initial begin
        err_cnt    = 0;
        rx_hold    = 0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_action   = sli_pkg::ACT_INSERT;
        i_value    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_extremes();
        test_full_list();
        wait_drained();
        test_backpressure();
        test_random(45);
        wait_drained();
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        rx_hold    = 0;
        test_random(30);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && pending_res.size() == 0)
            $display("sorted_list_insert_delete_top regression: pass");
        else
            $display("sorted_list_insert_delete_top regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/sli_pkg.sv
rtl/sli_datapath.sv
rtl/sli_ctrl.sv
rtl/sorted_list_insert_delete_top.sv
tb/sv/sorted_list_insert_delete_top_tb.sv
